>>> design/b2bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bds_pkg: shared types and constants for the binary to BCD digit scan
// Widths, conversion step counts and the job record passed from the
// converter to the digit scanner.
// ----------------------------------------------------------------------------
package b2bds_pkg;

    localparam int VALUE_W       = 32;
    localparam int DIGIT_W       = 4;
    localparam int COUNT_W       = 4;
    localparam int MAX_DIGITS    = 10;
    localparam int BCD_W         = MAX_DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);

    // Converted value with its shown digit count
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] count;
    } t_job;

    // Saturate a raw register value into the range 1..MAX_DIGITS
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] n;
        n = raw;
        if (n == '0) begin
            n = COUNT_W'(1);
        end else if (n > COUNT_W'(MAX_DIGITS)) begin
            n = COUNT_W'(MAX_DIGITS);
        end
        return n;
    endfunction

endpackage

>>> design/b2bds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bds_front: request intake and binary to BCD converter
// Takes a value and converts it with shift-and-add-3, four bits per cycle,
// then pushes the packed BCD word and digit count into the job queue.
// ----------------------------------------------------------------------------
module b2bds_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [b2bds_pkg::VALUE_W-1:0]    i_value,
    input  logic [b2bds_pkg::COUNT_W-1:0]    i_count,
    input  logic                             i_full,
    output logic                             o_push,
    output b2bds_pkg::t_job                  o_job
);
    import b2bds_pkg::*;

    // Four shift-and-add-3 iterations on the BCD and binary words
    function automatic logic [BCD_W+VALUE_W-1:0] dabble4(input logic [BCD_W-1:0] bcd,
                                                         input logic [VALUE_W-1:0] bin);
        logic [BCD_W+VALUE_W-1:0] acc;
        acc = {bcd, bin};
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (acc[VALUE_W + d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                    acc[VALUE_W + d*DIGIT_W +: DIGIT_W] =
                        acc[VALUE_W + d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            acc = acc << 1;
        end
        return acc;
    endfunction

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [VALUE_W-1:0]    r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [COUNT_W-1:0]    r_count;

    logic [BCD_W+VALUE_W-1:0] n_acc;
    logic                     last_step;
    logic                     accept;

    assign n_acc      = dabble4(r_bcd, r_bin);
    assign last_step  = r_busy && (r_step == STEP_W'(CONV_STEPS - 1));
    assign o_push     = last_step && !i_full;
    assign o_in_stall = r_busy && !o_push;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_job.bcd   = n_acc[VALUE_W +: BCD_W];
    assign o_job.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (o_push) begin
            r_busy <= 1'b0;
        end else if (r_busy && !last_step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin   <= i_value;
            r_bcd   <= '0;
            r_count <= i_count;
        end else if (r_busy && !last_step) begin
            r_bin <= n_acc[VALUE_W-1:0];
            r_bcd <= n_acc[VALUE_W +: BCD_W];
        end
    end

endmodule

>>> design/b2bds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bds_queue: short job queue
// Small FIFO between the converter and the digit scanner so either side
// can stall without holding the other until the queue fills or empties.
// ----------------------------------------------------------------------------
module b2bds_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b2bds_pkg::t_job    i_data,
    output logic               o_full,
    input  logic               i_pop,
    output b2bds_pkg::t_job    o_data,
    output logic               o_empty
);
    import b2bds_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QFILL_W-1:0]  r_fill;

    assign o_full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QFILL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - QFILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue read while empty");

endmodule

>>> design/b2bds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bds_back: digit scanner
// Loads a converted job, left-aligns the shown digits and emits one digit
// per unstalled cycle through the output register, most significant first.
// ----------------------------------------------------------------------------
module b2bds_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  b2bds_pkg::t_job                i_job,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [b2bds_pkg::COUNT_W-1:0]  o_digit_index,
    output logic [b2bds_pkg::DIGIT_W-1:0]  o_bcd_digit,
    output logic                           o_last
);
    import b2bds_pkg::*;

    localparam int SHIFT_W = $clog2(BCD_W);

    logic                 r_valid;
    logic [COUNT_W-1:0]   r_idx;
    logic [COUNT_W-1:0]   r_cnt;
    logic [BCD_W-1:0]     r_digits;

    logic                 take;
    logic                 last;
    logic [SHIFT_W-1:0]   align;

    assign last  = (r_idx == (r_cnt - COUNT_W'(1)));
    assign take  = r_valid && !i_out_stall;
    assign o_pop = !i_empty && (!r_valid || (take && last));
    // drop the unshown upper digits by shifting the shown ones to the top
    assign align = SHIFT_W'((MAX_DIGITS - 32'(i_job.count)) * DIGIT_W);

    assign o_out_valid   = r_valid;
    assign o_digit_index = r_idx;
    assign o_bcd_digit   = r_digits[BCD_W-1 -: DIGIT_W];
    assign o_last        = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (take && last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx    <= '0;
            r_cnt    <= i_job.count;
            r_digits <= i_job.bcd << align;
        end else if (take) begin
            r_idx    <= r_idx + COUNT_W'(1);
            r_digits <= r_digits << DIGIT_W;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != '0 && r_cnt <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count out of range in scanner");

    a_idx_below_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_cnt))
        else $error("digit index ran past digit count");

    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (o_bcd_digit <= DIGIT_W'(9)))
        else $error("non-decimal digit presented");

endmodule

>>> design/binary_to_bcd_digit_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_bcd_digit_scan: binary to BCD converter with digit scan output
// Splits a 32-bit value into BCD digits and scans out the low digit_count
// digits, most significant shown digit first, one request per digit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  in       | i_in_valid / o_in_stall   | i_value[31:0]
//  out      | o_out_valid / i_out_stall | o_digit_index, o_bcd_digit, o_last
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_data[3:0] (digit_count)
//
// Conversion uses shift-and-add-3, 4 bits per cycle; the scanner sends one
// digit per cycle while the output is not stalled. The converter takes a new
// value in the cycle it pushes the previous job, and a first digit passes the
// converter, the job queue and the scanner's output register. A two-entry
// job queue separates converter and scanner.
// Reset is synchronous, active low; digit_count resets to 3. No clearing pass.
// A stall on the output holds the scanner only; the converter runs on until
// the queue is full.
// ----------------------------------------------------------------------------
module binary_to_bcd_digit_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [b2bds_pkg::VALUE_W-1:0]  i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [b2bds_pkg::COUNT_W-1:0]  o_digit_index,
    output logic [b2bds_pkg::DIGIT_W-1:0]  o_bcd_digit,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [b2bds_pkg::COUNT_W-1:0]  i_cfg_data
);
    import b2bds_pkg::*;

    logic [COUNT_W-1:0] r_digit_count;
    logic [COUNT_W-1:0] count;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_job               push_job;
    t_job               pop_job;

    assign o_cfg_ready = 1'b1;
    assign count       = eff_count(r_digit_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_digit_count <= i_cfg_data;
        end
    end

    b2bds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_count    (count),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    b2bds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    b2bds_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (pop_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digit_index (o_digit_index),
        .o_bcd_digit   (o_bcd_digit),
        .o_last        (o_last)
    );

endmodule

>>> bench/bcd_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_digit_checker: digit scan predictor and result comparator
// Watches the value, digit and digit-count channels of the BCD digit scan.
// For every value taken it works out the shown digits, most significant
// first, and compares each digit request sent out against the oldest one due.
// ----------------------------------------------------------------------------
module bcd_digit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [b2bds_pkg::VALUE_W-1:0]  i_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [b2bds_pkg::COUNT_W-1:0]  i_digit_index,
    input  logic [b2bds_pkg::DIGIT_W-1:0]  i_bcd_digit,
    input  logic                           i_last,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [b2bds_pkg::COUNT_W-1:0]  i_cfg_data,
    output int                             o_mismatches,
    output int                             o_digits_pending
);

    import b2bds_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] index;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_shown_digit;

    t_shown_digit       digits_due[$];
    logic [COUNT_W-1:0] digit_count_reg = COUNT_RESET;
    int                 mismatches = 0;

    // Clamp the register into 1..MAX_DIGITS
    function automatic int shown_digits(input logic [COUNT_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > MAX_DIGITS) begin
            return MAX_DIGITS;
        end
        return int'(raw);
    endfunction

    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        logic [VALUE_W-1:0] rest;
        t_shown_digit       d;
        int                 n;
        n    = shown_digits(digit_count_reg);
        rest = value;
        // fill from the least significant shown position upward
        for (int pos = n - 1; pos >= 0; pos--) begin
            digits[pos] = DIGIT_W'(rest % 32'd10);
            rest        = rest / 32'd10;
        end
        for (int pos = 0; pos < n; pos++) begin
            d.index = COUNT_W'(pos);
            d.digit = digits[pos];
            d.last  = (pos == n - 1);
            digits_due.push_back(d);
        end
    endfunction

    always @(posedge i_clk) begin
        t_shown_digit want;
        if (!i_rst_n) begin
            digits_due.delete();
            digit_count_reg = COUNT_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                digit_count_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_digits(i_value);
            end
            if (i_out_valid && !i_out_stall) begin
                if (digits_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: digit request with none due: index %0d digit %0d last %0b",
                                 $realtime, i_digit_index, i_bcd_digit, i_last);
                    end
                end else begin
                    want = digits_due.pop_front();
                    if (want.index !== i_digit_index || want.digit !== i_bcd_digit ||
                        want.last !== i_last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: digit mismatch: expected index %0d digit %0d",
                                     $realtime, want.index, want.digit,
                                     " last %0b, got index %0d digit %0d last %0b",
                                     want.last, i_digit_index, i_bcd_digit, i_last);
                        end
                    end
                end
            end
        end
        o_mismatches     = mismatches;
        o_digits_pending = digits_due.size();
    end

endmodule

>>> bench/binary_to_bcd_digit_scan_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_bcd_digit_scan_test: testbench for the BCD digit scan
// Drives values through a directed set of edge cases and a random run over
// many digit counts, with random gaps and stalls on both sides, a long output
// hold-off and drained pauses for register writes. Checking is done by the
// digit checker beside the block; this module only stimulates and judges.
// ----------------------------------------------------------------------------
module binary_to_bcd_digit_scan_test;

    import b2bds_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 24;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_VALUES   = 12;
    localparam int FLOOD_PHASE    = 3;
    localparam int FLOOD_VALUES   = 24;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [VALUE_W-1:0]   i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [COUNT_W-1:0]   o_digit_index;
    logic [DIGIT_W-1:0]   o_bcd_digit;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data;

    int                   mismatches;
    int                   digits_pending;
    int                   cycles = 0;
    bit                   flood = 1'b0;
    bit                   stall_burst_due = 1'b0;

    binary_to_bcd_digit_scan uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digit_index (o_digit_index),
        .o_bcd_digit   (o_bcd_digit),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    bcd_digit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_value          (i_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_digit_index    (o_digit_index),
        .i_bcd_digit      (o_bcd_digit),
        .i_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_digits_pending (digits_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("binary_to_bcd_digit_scan_test: errors");
            $finish;
        end
    end

    // Digit receiver: random stall runs, plus one long hold when asked
    initial begin
        int r;
        int len;
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (stall_burst_due) begin
                stall_burst_due = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(1, 24);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(8, 40);
                end
                repeat (len) @(negedge i_clk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (flood || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] p;
        int                 k;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return VALUE_W'($urandom_range(0, 99));
            1: return VALUE_W'($urandom_range(0, 99999));
            2, 3: return $urandom;
            4: begin
                // a power of ten or one below it
                k = $urandom_range(0, 9);
                repeat (k) p = p * 32'd10;
                return p - VALUE_W'($urandom_range(0, 1));
            end
            default: return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Offer one value; returns at the edge that takes it
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold the sender until every digit due has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (digits_pending != 0) @(negedge i_clk);
    endtask

    task automatic set_digit_count(input logic [COUNT_W-1:0] n);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset digit count, leading zeros and wrap-around
        offer_value(32'd0);
        offer_value(32'd1);
        offer_value(32'd9);
        offer_value(32'd10);
        offer_value(32'd999);
        offer_value(32'd1000);
        offer_value(32'd123456);
        offer_value(32'hFFFF_FFFF);

        set_digit_count(COUNT_W'(10));
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd1000000000);
        offer_value(32'd999999999);
        offer_value(32'd0);
        offer_value(32'h8000_0000);

        // zero count clamps to one digit
        set_digit_count(COUNT_W'(0));
        offer_value(32'd7);
        offer_value(32'hFFFF_FFFF);

        // count above the maximum clamps to ten digits
        set_digit_count(COUNT_W'(15));
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd1234567890);

        set_digit_count(COUNT_W'(1));
        offer_value(32'd19);
        offer_value(32'd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == FLOOD_PHASE) begin
                // back-to-back values against a long output hold-off
                set_digit_count(COUNT_W'(MAX_DIGITS));
                flood           = 1'b1;
                stall_burst_due = 1'b1;
                repeat (FLOOD_VALUES) offer_value(random_value());
                flood = 1'b0;
                drain_results();
            end else begin
                set_digit_count(COUNT_W'($urandom_range(0, 15)));
                repeat (PHASE_VALUES) offer_value(random_value());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && digits_pending == 0) begin
            $display("binary_to_bcd_digit_scan_test: clean");
        end else begin
            $display("binary_to_bcd_digit_scan_test: errors");
        end
        $finish;
    end

endmodule
